// ===== src/utf8_winansi_text_checker_defines.svh =====
// Assertion macros used by the text checker decoder.
`ifndef UTF8_WINANSI_TEXT_CHECKER_DEFINES_SVH
`define UTF8_WINANSI_TEXT_CHECKER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define UWTC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uwtc assertion failed");
// Next-cycle implication, checked outside reset.
`define UWTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uwtc assertion failed");
`else
`define UWTC_ASSERT_NOW(label, clk, rst, ante, cons)
`define UWTC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/uwtc_pkg.sv =====
// Types, constants and the WinAnsi membership function for the text checker.
package uwtc_pkg;

   // Byte that ends a text.
   localparam logic [7:0] TEXT_END = 8'h00;

   // Lead byte ranges.
   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD2_LO    = 8'hc2;
   localparam logic [7:0] LEAD2_HI    = 8'hdf;
   localparam logic [7:0] LEAD3_LO    = 8'he0;
   localparam logic [7:0] LEAD3_HI    = 8'hef;

   // Continuation byte tag in the top two bits.
   localparam logic [1:0] CONT_TAG = 2'b10;

   // Code point limits.
   localparam logic [15:0] OVERLONG_LIMIT = 16'h0800;
   localparam logic [15:0] SURR_LO        = 16'hd800;
   localparam logic [15:0] SURR_HI        = 16'hdfff;

   // Continuation bytes still expected.
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;

   // Width of the gathered code point bits before the last continuation byte.
   localparam int PARTIAL_W = 10;

   localparam int NUM_SPECIALS = 27;

   // Code points outside the plain ranges that WinAnsi still maps.
   localparam logic [15:0] WINANSI_SPECIALS [NUM_SPECIALS] = '{
      16'h20ac, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
      16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017d, 16'h2018,
      16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014, 16'h02dc,
      16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'h017e, 16'h0178
   };

   // One result beat handed from the decoder to the result register.
   typedef struct packed {
      logic push;
      logic ok;
   } uwtc_result_type;

   // True when the code point is printable ASCII, Latin-1 0xa0 to 0xff,
   // tab, LF, CR or one of the special code points.
   function automatic logic in_winansi(input logic [15:0] cp);
      logic hit;
      hit = ((cp >= 16'h0020) && (cp <= 16'h007e)) ||
            ((cp >= 16'h00a0) && (cp <= 16'h00ff)) ||
            (cp == 16'h0009) || (cp == 16'h000a) || (cp == 16'h000d);
      for (int k = 0; k < NUM_SPECIALS; k++) begin
         if (WINANSI_SPECIALS[k] == cp) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

// ===== src/uwtc_channels.sv =====
// Valid/ready channel interfaces for the text byte input and the result output.
interface uwtc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface uwtc_rsp_if;
   logic valid;
   logic ready;
   logic text_ok;

   modport source (output valid, output text_ok, input ready);
   modport sink (input valid, input text_ok, output ready);
endinterface

// ===== src/utf8_winansi_text_checker.sv =====
// Top level of the UTF-8 WinAnsi text checker.
//
//   Channel   Direction  Payload           Beat
//   req_bus   in         text_byte [7:0]   one text byte, zero ends the text
//   rsp_bus   out        text_ok           one verdict per text
//
// One byte is taken every cycle unless a zero byte waits in the input
// register; the decoder sits between the input register and the result
// register, where the verdict for each zero byte is registered.
// Reset is synchronous and clears the decoder state and both valid flags.
// A zero byte waits in the input register only while the result register
// holds a verdict that the sink has not taken; other bytes never wait.
module utf8_winansi_text_checker (
   input  logic       clock,
   input  logic       reset,
   uwtc_req_if.sink   req_bus,
   uwtc_rsp_if.source rsp_bus
);
   import uwtc_pkg::*;

   logic            byte_vld;
   logic [7:0]      byte_val;
   logic            pop;
   logic            out_space;
   uwtc_result_type result;

   // Input register.
   uwtc_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .pop      (pop),
      .byte_vld (byte_vld),
      .byte_val (byte_val)
   );

   // Sequence decoder and checks.
   uwtc_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .byte_vld  (byte_vld),
      .byte_val  (byte_val),
      .out_space (out_space),
      .pop       (pop),
      .result    (result)
   );

   // Result register.
   uwtc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .out_space (out_space),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== src/uwtc_in_stage.sv =====
// Input register that holds one text byte until the decoder consumes it.
module uwtc_in_stage (
   input  logic       clock,
   input  logic       reset,
   uwtc_req_if.sink   req_bus,
   input  logic       pop,
   output logic       byte_vld,
   output logic [7:0] byte_val
);
   import uwtc_pkg::*;

   logic       vld_ff;
   logic       vld_in;
   logic [7:0] byte_ff;
   logic       take;

   // A new beat is taken when the register is empty or drains this cycle.
   assign req_bus.ready = !vld_ff || pop;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (pop) begin
         vld_in = 1'b0;
      end
   end

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Byte payload.
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_bus.text_byte;
      end
   end

   assign byte_vld = vld_ff;
   assign byte_val = byte_ff;

endmodule

// ===== src/uwtc_decoder.sv =====
// UTF-8 sequence decoder and WinAnsi check with the per-text error latch.
`include "utf8_winansi_text_checker_defines.svh"

module uwtc_decoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      byte_vld,
   input  logic [7:0]                byte_val,
   input  logic                      out_space,
   output logic                      pop,
   output uwtc_pkg::uwtc_result_type result
);
   import uwtc_pkg::*;

   logic [1:0]           pending_ff;
   logic [1:0]           pending_in;
   logic [PARTIAL_W-1:0] partial_ff;
   logic [PARTIAL_W-1:0] partial_in;
   logic                 three_ff;
   logic                 three_in;
   logic                 error_ff;
   logic                 error_in;
   logic                 is_end;
   logic [15:0]          cp;

   // The end byte needs room in the result register; other bytes never wait.
   assign is_end = (byte_val == TEXT_END);
   assign pop    = byte_vld && (!is_end || out_space);

   // Code point with this byte appended as a continuation.
   assign cp = {partial_ff, byte_val[5:0]};

   // Next decoder state and result for the byte in the input register.
   always_comb begin
      pending_in  = pending_ff;
      partial_in  = partial_ff;
      three_in    = three_ff;
      error_in    = error_ff;
      result.push = 1'b0;
      result.ok   = 1'b0;
      if (pop) begin
         if (is_end) begin
            result.push = 1'b1;
            result.ok   = !error_ff && (pending_ff == PEND_NONE);
            pending_in  = PEND_NONE;
            partial_in  = '0;
            three_in    = 1'b0;
            error_in    = 1'b0;
         end else if (error_ff) begin
            pending_in = PEND_NONE;
            partial_in = '0;
            three_in   = 1'b0;
         end else if (pending_ff != PEND_NONE) begin
            if (byte_val[7:6] != CONT_TAG) begin
               error_in   = 1'b1;
               pending_in = PEND_NONE;
               partial_in = '0;
               three_in   = 1'b0;
            end else if (pending_ff == PEND_ONE) begin
               // Last continuation byte: check the finished code point.
               if ((three_ff && (cp < OVERLONG_LIMIT)) ||
                   ((cp >= SURR_LO) && (cp <= SURR_HI)) || !in_winansi(cp)) begin
                  error_in = 1'b1;
               end
               pending_in = PEND_NONE;
               partial_in = '0;
               three_in   = 1'b0;
            end else begin
               pending_in = pending_ff - 2'd1;
               partial_in = cp[PARTIAL_W-1:0];
            end
         end else if (byte_val < ASCII_LIMIT) begin
            if (!in_winansi({8'h00, byte_val})) begin
               error_in = 1'b1;
            end
         end else if ((byte_val >= LEAD2_LO) && (byte_val <= LEAD2_HI)) begin
            partial_in = {{(PARTIAL_W-5){1'b0}}, byte_val[4:0]};
            pending_in = PEND_ONE;
            three_in   = 1'b0;
         end else if ((byte_val >= LEAD3_LO) && (byte_val <= LEAD3_HI)) begin
            partial_in = {{(PARTIAL_W-4){1'b0}}, byte_val[3:0]};
            pending_in = PEND_TWO;
            three_in   = 1'b1;
         end else begin
            error_in = 1'b1;
         end
      end
   end

   // Control state of the current sequence and text.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PEND_NONE;
         three_ff   <= 1'b0;
         error_ff   <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         three_ff   <= three_in;
         error_ff   <= error_in;
      end
   end

   // Gathered code point bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
      end else begin
         partial_ff <= partial_in;
      end
   end

   // At most two continuation bytes are ever expected.
   `UWTC_ASSERT_NOW(a_pending_range, clock, reset, 1'b1, pending_ff != 2'd3)
   // A latched error always leaves no sequence open.
   `UWTC_ASSERT_NOW(a_error_no_seq, clock, reset, error_ff, pending_ff == PEND_NONE)
   // The end byte leaves the decoder fully cleared.
   `UWTC_ASSERT_NEXT(a_end_clears, clock, reset, pop && is_end,
                     (pending_ff == PEND_NONE) && !error_ff && !three_ff)

endmodule

// ===== src/uwtc_out_stage.sv =====
// Result register that holds one verdict until the sink takes it.
module uwtc_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  uwtc_pkg::uwtc_result_type result,
   output logic                      out_space,
   uwtc_rsp_if.source                rsp_bus
);
   import uwtc_pkg::*;

   logic vld_ff;
   logic vld_in;
   logic ok_ff;

   // Room exists when empty or when the held beat leaves this cycle.
   assign out_space = !vld_ff || rsp_bus.ready;

   always_comb begin
      vld_in = vld_ff;
      if (result.push) begin
         vld_in = 1'b1;
      end else if (rsp_bus.ready) begin
         vld_in = 1'b0;
      end
   end

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Verdict payload.
   always_ff @(posedge clock) begin
      if (result.push) begin
         ok_ff <= result.ok;
      end
   end

   assign rsp_bus.valid   = vld_ff;
   assign rsp_bus.text_ok = ok_ff;

endmodule

// ===== tb/tb_utf8_winansi_text_checker.sv =====
// Self-checking testbench for the UTF-8 WinAnsi text checker with random idling and backpressure.
`timescale 1ns / 1ps

module tb_utf8_winansi_text_checker;
   import uwtc_pkg::*;

   localparam int TEXT_BYTE_TARGET = 1750;
   localparam int STALL_LIMIT      = 2000;
   localparam int LONG_HOLD        = 400;
   localparam int DRAIN_CYCLES     = 8;
   localparam int OPENING_LEN      = 33;

   // Short texts that hit the edges: empty text, plain ranges and specials,
   // DEL, an overlong form, a surrogate, a bad continuation, a text cut off
   // inside a sequence, and a bad lead byte.
   localparam logic [7:0] OPENING_BYTES [OPENING_LEN] = '{
      8'h00,
      8'h20, 8'h7e, 8'h09, 8'h0a, 8'h0d, 8'hc2, 8'ha0, 8'hc3, 8'hbf,
      8'he2, 8'h82, 8'hac, 8'h00,
      8'h7f, 8'h00,
      8'he0, 8'h81, 8'h81, 8'h00,
      8'hed, 8'ha0, 8'h80, 8'h00,
      8'hc2, 8'h41, 8'h00,
      8'he2, 8'h82, 8'h00,
      8'hff, 8'h80, 8'h00
   };

   logic clock = 1'b0;
   logic reset;

   uwtc_req_if req_if ();
   uwtc_rsp_if rsp_if ();

   utf8_winansi_text_checker uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always #5 clock = ~clock;

   // Bytes waiting to be sent and verdicts waiting to arrive.
   logic [7:0] queued_bytes [$];
   bit         expected_verdicts [$];

   // Decoder state mirrored by the predictor.
   logic [1:0]  cont_left;
   logic [15:0] code_acc;
   bit          wide_form;
   bit          text_bad;

   int  bytes_planned;
   int  bytes_accepted;
   int  verdicts_seen;
   int  mismatches;
   int  stall_cycles;
   bit  byte_taken;
   bit  verdict_taken;
   int  send_wait;
   int  send_calm;
   int  recv_wait;
   int  recv_calm;

   // Membership of a code point in the WinAnsi repertoire.
   function automatic bit winansi_member(input logic [15:0] cp);
      bit hit;
      hit = (cp >= 16'h0020 && cp <= 16'h007e) || (cp >= 16'h00a0 && cp <= 16'h00ff) ||
            cp == 16'h0009 || cp == 16'h000a || cp == 16'h000d;
      for (int k = 0; k < NUM_SPECIALS; k++) begin
         if (WINANSI_SPECIALS[k] == cp) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // Idle count for one beat; now and then a run of beats without any idling.
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if ($urandom_range(0, 1) == 0) begin
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   task automatic drop_sequence();
      cont_left = PEND_NONE;
      code_acc  = '0;
      wide_form = 1'b0;
   endtask

   // Advances the predicted decoder by one accepted byte; a zero byte yields a verdict.
   task automatic scan_text_byte(input logic [7:0] b);
      logic [15:0] cp;
      if (b == TEXT_END) begin
         expected_verdicts.push_back(!text_bad && cont_left == PEND_NONE);
         drop_sequence();
         text_bad = 1'b0;
      end else if (text_bad) begin
         drop_sequence();
      end else if (cont_left != PEND_NONE) begin
         if (b[7:6] != CONT_TAG) begin
            text_bad = 1'b1;
            drop_sequence();
         end else begin
            cp        = {code_acc[9:0], b[5:0]};
            code_acc  = cp;
            cont_left = cont_left - 2'd1;
            if (cont_left == PEND_NONE) begin
               if ((wide_form && cp < OVERLONG_LIMIT) || (cp >= SURR_LO && cp <= SURR_HI) ||
                   !winansi_member(cp)) begin
                  text_bad = 1'b1;
               end
               drop_sequence();
            end
         end
      end else if (b < ASCII_LIMIT) begin
         if (!winansi_member({8'h00, b})) begin
            text_bad = 1'b1;
         end
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         code_acc  = {11'd0, b[4:0]};
         cont_left = PEND_ONE;
         wide_form = 1'b0;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
         code_acc  = {12'd0, b[3:0]};
         cont_left = PEND_TWO;
         wide_form = 1'b1;
      end else begin
         text_bad = 1'b1;
      end
   endtask

   // Queues the UTF-8 encoding of a nonzero code point.
   task automatic push_code_point(input logic [15:0] cp);
      if (cp < 16'h0080) begin
         queued_bytes.push_back(cp[7:0]);
      end else if (cp < 16'h0800) begin
         queued_bytes.push_back({3'b110, cp[10:6]});
         queued_bytes.push_back({CONT_TAG, cp[5:0]});
      end else begin
         queued_bytes.push_back({4'b1110, cp[15:12]});
         queued_bytes.push_back({CONT_TAG, cp[11:6]});
         queued_bytes.push_back({CONT_TAG, cp[5:0]});
      end
   endtask

   // One character of a text; clean texts draw only from the valid kinds.
   task automatic push_character(input bit clean);
      int          pick;
      int          k;
      logic [15:0] cp;
      pick = clean ? $urandom_range(0, 74) : $urandom_range(0, 99);
      k    = $urandom_range(0, NUM_SPECIALS - 1);
      if (pick < 44) begin
         push_code_point(16'($urandom_range(16'h0020, 16'h007e)));
      end else if (pick < 50) begin
         case ($urandom_range(0, 2))
            0: push_code_point(16'h0009);
            1: push_code_point(16'h000a);
            default: push_code_point(16'h000d);
         endcase
      end else if (pick < 65) begin
         push_code_point(16'($urandom_range(16'h00a0, 16'h00ff)));
      end else if (pick < 75) begin
         push_code_point(WINANSI_SPECIALS[k]);
      end else if (pick < 80) begin
         // Control characters and DEL; all but tab, LF and CR are outside the set.
         cp = ($urandom_range(0, 3) == 0) ? 16'h007f
                                          : 16'($urandom_range(16'h0001, 16'h001f));
         push_code_point(cp);
      end else if (pick < 85) begin
         push_code_point(16'($urandom_range(16'h0080, 16'h07ff)));
      end else if (pick < 90) begin
         cp = $urandom_range(0, 1) ? 16'($urandom_range(16'hd800, 16'hdfff))
                                   : 16'($urandom_range(16'h0800, 16'hffff));
         push_code_point(cp);
      end else if (pick < 93) begin
         // Overlong three-byte form.
         queued_bytes.push_back(LEAD3_LO);
         queued_bytes.push_back(8'($urandom_range(8'h80, 8'h9f)));
         queued_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
      end else if (pick < 96) begin
         queued_bytes.push_back(8'($urandom_range(8'h01, 8'hff)));
      end else if (pick < 98) begin
         // A sequence cut short by whatever follows it.
         if ($urandom_range(0, 1)) begin
            queued_bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
         end else begin
            queued_bytes.push_back(8'($urandom_range(LEAD3_LO, LEAD3_HI)));
            if ($urandom_range(0, 1)) begin
               queued_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
            end
         end
      end else begin
         // Neighbors of a special code point.
         cp = $urandom_range(0, 1) ? WINANSI_SPECIALS[k] + 16'd1 : WINANSI_SPECIALS[k] - 16'd1;
         push_code_point(cp);
      end
   endtask

   // Sender: offers the next byte after its drawn idle time.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || byte_taken) begin
         if (byte_taken) begin
            byte_taken = 1'b0;
            send_wait  = draw_wait(send_calm);
         end
         if (send_wait > 0) begin
            req_if.valid <= 1'b0;
            send_wait--;
         end else if (queued_bytes.size() > 0) begin
            req_if.valid     <= 1'b1;
            req_if.text_byte <= queued_bytes.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: may stall after each verdict, with two long hold-offs to back up the block.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (verdict_taken) begin
            verdict_taken = 1'b0;
            if (verdicts_seen == 20 || verdicts_seen == 75) begin
               recv_wait = LONG_HOLD;
            end else begin
               recv_wait = draw_wait(recv_calm);
            end
         end
         if (recv_wait > 0) begin
            rsp_if.ready <= 1'b0;
            recv_wait--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Monitor: feeds accepted bytes to the predictor and checks each verdict beat.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            scan_text_byte(req_if.text_byte);
            byte_taken = 1'b1;
            bytes_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: verdict %0b arrived with none expected", $time, rsp_if.text_ok);
               mismatches++;
            end else if (rsp_if.text_ok !== expected_verdicts[0]) begin
               $display("%0t: text_ok expected %0b, actual %0b",
                        $time, expected_verdicts[0], rsp_if.text_ok);
               mismatches++;
               void'(expected_verdicts.pop_front());
            end else begin
               void'(expected_verdicts.pop_front());
            end
            verdict_taken = 1'b1;
            verdicts_seen++;
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int len;
      bit clean;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.text_byte = 8'h00;
      rsp_if.ready     = 1'b0;
      cont_left        = PEND_NONE;
      code_acc         = '0;
      wide_form        = 1'b0;
      text_bad         = 1'b0;

      for (int i = 0; i < OPENING_LEN; i++) begin
         queued_bytes.push_back(OPENING_BYTES[i]);
      end
      // Mostly clean texts with random content, the rest carry errors and noise.
      while (queued_bytes.size() < TEXT_BYTE_TARGET) begin
         clean = ($urandom_range(0, 9) < 6);
         len   = $urandom_range(0, 12);
         for (int i = 0; i < len; i++) begin
            push_character(clean);
         end
         queued_bytes.push_back(TEXT_END);
      end
      bytes_planned = queued_bytes.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while ((bytes_accepted < bytes_planned || expected_verdicts.size() != 0) &&
             stall_cycles < STALL_LIMIT) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat on either channel for %0d cycles", $time, STALL_LIMIT);
      end
      if (stall_cycles < STALL_LIMIT && mismatches == 0) begin
         $display("utf8_winansi_text_checker: match");
      end else begin
         $display("utf8_winansi_text_checker: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/uwtc_pkg.sv
src/uwtc_channels.sv
src/uwtc_in_stage.sv
src/uwtc_decoder.sv
src/uwtc_out_stage.sv
src/utf8_winansi_text_checker.sv
tb/tb_utf8_winansi_text_checker.sv
